FILE: hw/rtl/mwrs_pkg.sv
`default_nettype none

package mwrs_pkg;

    // Width of the window length register and its value after reset.
    localparam int LEN_W = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd14;

    // Width of the slope result, signed Q41.0, a whole number with no fraction bits.
    localparam int SLOPE_W = 41;

    // What the front part decided about one word.
    typedef struct packed {
        logic store;   // the sample goes into the ring
        logic valid;   // the window is full and long enough for a fit
    } job_flags_t;

    localparam int FLAGS_W = $bits(job_flags_t);

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_DRAIN,
        B_SCALE,
        B_ABS,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mwrs_ram.sv
`default_nettype none

module mwrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mwrs_queue.sv
`default_nettype none

// Two-entry queue between the front and back parts.
module mwrs_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mwrs_front.sv
`default_nettype none

// Takes input words, keeps the ring pointer and the sample count, and decides
// for each word where its sample goes and which window the back part fits.
module mwrs_front #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mwrs_pkg::LEN_W-1:0]       cfg_wr_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]    sample,
    input  wire logic                             sample_missing,
    input  wire logic                             group_start,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output mwrs_pkg::job_flags_t                  job_flags,
    output logic [$clog2(WINDOW_MAX)-1:0]         job_wr_addr,
    output logic [SAMPLE_BITS-1:0]                job_sample,
    output logic [$clog2(WINDOW_MAX)-1:0]         job_start,
    output logic [$clog2(WINDOW_MAX+1)-1:0]       job_n
);

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (CNT_W > mwrs_pkg::LEN_W) ? CNT_W : mwrs_pkg::LEN_W;

    logic [mwrs_pkg::LEN_W-1:0] len_reg;
    logic [ADDR_W-1:0]          wp_reg;
    logic [ADDR_W-1:0]          wp_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [ADDR_W-1:0]          wp_base;
    logic [CNT_W-1:0]           cnt_base;
    logic [CMP_W-1:0]           len_ext;
    logic [CMP_W-1:0]           n_full;
    logic [CNT_W-1:0]           n;
    logic [CNT_W:0]             wp_x;
    logic [CNT_W:0]             n_x;
    logic [CNT_W:0]             start_x;
    logic                       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    always_comb
    begin
        // Group start clears the pointer and count before this word is taken.
        wp_base  = group_start ? '0 : wp_reg;
        cnt_base = group_start ? '0 : cnt_reg;
        wp_next  = wp_base;
        cnt_next = cnt_base;
        if (!sample_missing)
        begin
            wp_next = (wp_base == ADDR_W'(WINDOW_MAX - 1)) ? '0 : wp_base + ADDR_W'(1);
            if (cnt_base != CNT_W'(WINDOW_MAX))
            begin
                cnt_next = cnt_base + CNT_W'(1);
            end
        end

        len_ext = CMP_W'(len_reg);
        n_full  = (len_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : len_ext;
        n       = CNT_W'(n_full);

        // Oldest sample of the window, modulo the ring depth.
        wp_x    = (CNT_W + 1)'(wp_next);
        n_x     = (CNT_W + 1)'(n);
        start_x = (wp_x >= n_x) ? (wp_x - n_x) : (wp_x + (CNT_W + 1)'(WINDOW_MAX) - n_x);

        job_flags.store = !sample_missing;
        job_flags.valid = (n > CNT_W'(1)) && (cnt_next >= n);
        job_wr_addr     = wp_base;
        job_sample      = sample;
        job_start       = ADDR_W'(start_x);
        job_n           = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= mwrs_pkg::LEN_RESET;
            wp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                wp_reg  <= wp_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mwrs_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mwrs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 21
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int DCNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [NUM_W-1:0]  quo_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  dsr_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              take;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        take     = !diff[DEN_W];
        rem_next = take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DCNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mwrs_back.sv
`default_nettype none

// Carries out one queued job: stores the sample, and if a fit is due sums the
// window with centered weights, scales, divides, saturates; holds the result word.
module mwrs_back #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_empty,
    output logic                                    q_pop,
    input  wire mwrs_pkg::job_flags_t               job_flags,
    input  wire logic [$clog2(WINDOW_MAX)-1:0]      job_start,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]    job_n,
    output logic                                    ram_we,
    output logic      [$clog2(WINDOW_MAX)-1:0]      ram_raddr,
    input  wire logic signed [SAMPLE_BITS-1:0]      ram_rdata,
    output logic                                    div_start,
    output logic [SAMPLE_BITS+2*$clog2(WINDOW_MAX)+3:0] div_dividend,
    output logic [3*$clog2(WINDOW_MAX+1)-1:0]       div_divisor,
    input  wire logic                               div_done,
    input  wire logic [SAMPLE_BITS+2*$clog2(WINDOW_MAX)+3:0] div_quotient,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [mwrs_pkg::SLOPE_W-1:0]     slope,
    output logic                                    slope_valid
);

    localparam int ADDR_W  = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int COEF_W  = CNT_W + 1;
    localparam int PROD_W  = COEF_W + SAMPLE_BITS;
    localparam int ACC_W   = SAMPLE_BITS + 2 * ADDR_W + 1;
    localparam int NUM_W   = ACC_W + 3;
    localparam int DENA_W  = 2 * CNT_W;
    localparam int DEN_W   = 3 * CNT_W;
    localparam int SLOPE_W = mwrs_pkg::SLOPE_W;
    localparam int WIDE_W  = ((NUM_W > SLOPE_W) ? NUM_W : SLOPE_W) + 1;
    localparam logic [WIDE_W-1:0] NEG_LIM = WIDE_W'(1) << (SLOPE_W - 1);
    localparam logic [WIDE_W-1:0] POS_LIM = NEG_LIM - WIDE_W'(1);

    mwrs_pkg::back_state_t state_reg;
    mwrs_pkg::back_state_t state_next;

    logic                      take_job;
    logic                      issue;
    logic                      load_out;
    logic                      finish_div;

    logic [ADDR_W-1:0]         addr_reg;
    logic [CNT_W-1:0]          left_reg;
    logic [CNT_W-1:0]          n_reg;
    logic signed [COEF_W-1:0]  coef_reg;
    logic signed [COEF_W-1:0]  coef1_reg;
    logic                      d1_v_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      p_v_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic                      neg_reg;
    logic [DENA_W-1:0]         den_a_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [SLOPE_W-1:0]        res_slope_reg;
    logic                      res_valid_reg;
    logic                      out_valid_reg;
    logic [SLOPE_W-1:0]        out_slope_reg;
    logic                      out_flag_reg;

    logic [WIDE_W-1:0]         q_wide;
    logic [WIDE_W-1:0]         q_clip;
    logic [SLOPE_W-1:0]        sat_slope;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwrs_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = job_flags.valid ? mwrs_pkg::B_READ : mwrs_pkg::B_OUT;
                end
            end
            mwrs_pkg::B_READ:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = mwrs_pkg::B_DRAIN;
                end
            end
            mwrs_pkg::B_DRAIN:
            begin
                if (!d1_v_reg && !p_v_reg)
                begin
                    state_next = mwrs_pkg::B_SCALE;
                end
            end
            mwrs_pkg::B_SCALE:
            begin
                state_next = mwrs_pkg::B_ABS;
            end
            mwrs_pkg::B_ABS:
            begin
                state_next = mwrs_pkg::B_DIV;
            end
            mwrs_pkg::B_DIV:
            begin
                if (div_done)
                begin
                    state_next = mwrs_pkg::B_OUT;
                end
            end
            mwrs_pkg::B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = mwrs_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mwrs_pkg::B_IDLE;
            end
        endcase
    end

    // Output and control logic.
    always_comb
    begin
        take_job   = 1'b0;
        issue      = 1'b0;
        div_start  = 1'b0;
        finish_div = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            mwrs_pkg::B_IDLE:  take_job   = !q_empty;
            mwrs_pkg::B_READ:  issue      = 1'b1;
            mwrs_pkg::B_ABS:   div_start  = 1'b1;
            mwrs_pkg::B_DIV:   finish_div = div_done;
            mwrs_pkg::B_OUT:   load_out   = !out_valid_reg || out_ready;
            default:
            begin
                take_job = 1'b0;
            end
        endcase
        q_pop  = take_job;
        ram_we = take_job && job_flags.store;
    end

    assign ram_raddr    = addr_reg;
    // The divider loads the magnitude while the sign flag is still being
    // registered, so the sign is taken straight from the numerator here.
    assign div_dividend = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign div_divisor  = den_reg;

    // Truncated quotient clipped to the slope range, sign restored.
    always_comb
    begin
        q_wide = WIDE_W'(div_quotient);
        if (neg_reg)
        begin
            q_clip    = (q_wide > NEG_LIM) ? NEG_LIM : q_wide;
            sat_slope = -SLOPE_W'(q_clip);
        end
        else
        begin
            q_clip    = (q_wide > POS_LIM) ? POS_LIM : q_wide;
            sat_slope = SLOPE_W'(q_clip);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwrs_pkg::B_IDLE;
            d1_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            d1_v_reg  <= issue;
            p_v_reg   <= d1_v_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_job)
        begin
            addr_reg      <= job_start;
            left_reg      <= job_n;
            n_reg         <= job_n;
            coef_reg      <= COEF_W'(1) - COEF_W'(job_n);
            acc_reg       <= '0;
            res_slope_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            addr_reg <= (addr_reg == ADDR_W'(WINDOW_MAX - 1)) ? '0 : addr_reg + ADDR_W'(1);
            left_reg <= left_reg - CNT_W'(1);
            coef_reg <= coef_reg + COEF_W'(2);
        end

        // Weight 2i-(N-1) for the sample at window position i.
        coef1_reg <= coef_reg;
        prod_reg  <= coef1_reg * ram_rdata;
        if (p_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end

        // Denominator (N-1)N(N+1), settled long before the divider starts.
        den_a_reg <= DENA_W'(n_reg - CNT_W'(1)) * DENA_W'(n_reg);
        den_reg   <= DEN_W'(den_a_reg) * DEN_W'(n_reg + CNT_W'(1));

        if (state_reg == mwrs_pkg::B_SCALE)
        begin
            num_reg <= (NUM_W'(acc_reg) <<< 2) + (NUM_W'(acc_reg) <<< 1);
        end
        if (state_reg == mwrs_pkg::B_ABS)
        begin
            neg_reg <= num_reg[NUM_W-1];
        end
        if (finish_div)
        begin
            res_slope_reg <= sat_slope;
            res_valid_reg <= 1'b1;
        end
        if (load_out)
        begin
            out_slope_reg <= res_slope_reg;
            out_flag_reg  <= res_valid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slope       = out_slope_reg;
    assign slope_valid = out_flag_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/moving_window_regression_slope.sv
`default_nettype none

// Channel   Signals                                      Direction  Handshake
// input     sample, sample_missing, group_start          in         in_valid / in_ready
// output    slope, slope_valid                           out        out_valid / out_ready
// config    cfg_wr_data (window length)                  in         cfg_wr_en, no wait
//
// In the back part, a word with a valid result goes through the window pass over
// its N samples (N is the effective window length), scaling, absolute value and
// the divider; a word with an invalid result goes straight to the output step.
// The window pass reads one ring entry per cycle from a sample memory with
// separate read and write ports, and the restoring divider yields one quotient
// bit per cycle. A two-word queue lets the front keep accepting while the back
// works or while a result waits in the output register. Reset is asynchronous
// and active low; it clears the pointer, count, window length (to 14) and all
// handshake state, but not the sample ring, which is only read once written.
module moving_window_regression_slope #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [mwrs_pkg::LEN_W-1:0]           cfg_wr_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample,
    input  wire logic                                 sample_missing,
    input  wire logic                                 group_start,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [mwrs_pkg::SLOPE_W-1:0]       slope,
    output logic                                      slope_valid
);

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int NUM_W  = SAMPLE_BITS + 2 * ADDR_W + 4;
    localparam int DEN_W  = 3 * CNT_W;
    localparam int JOB_W  = mwrs_pkg::FLAGS_W + 2 * ADDR_W + SAMPLE_BITS + CNT_W;

    // Front to queue.
    logic                  q_push;
    logic                  q_full;
    mwrs_pkg::job_flags_t  f_flags;
    logic [ADDR_W-1:0]     f_wr_addr;
    logic [SAMPLE_BITS-1:0] f_sample;
    logic [ADDR_W-1:0]     f_start;
    logic [CNT_W-1:0]      f_n;
    logic [JOB_W-1:0]      q_wdata;

    // Queue to back.
    logic                  q_pop;
    logic                  q_empty;
    logic [JOB_W-1:0]      q_rdata;
    mwrs_pkg::job_flags_t  b_flags;
    logic [ADDR_W-1:0]     b_wr_addr;
    logic [SAMPLE_BITS-1:0] b_sample;
    logic [ADDR_W-1:0]     b_start;
    logic [CNT_W-1:0]      b_n;

    // Sample ring and divider.
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                  div_start;
    logic [NUM_W-1:0]      div_dividend;
    logic [DEN_W-1:0]      div_divisor;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quotient;

    // The front classifies each word: where its sample lands in the ring,
    // which stretch of the ring forms its window, and whether a fit is due.
    mwrs_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .sample_missing (sample_missing),
        .group_start    (group_start),
        .q_full         (q_full),
        .q_push         (q_push),
        .job_flags      (f_flags),
        .job_wr_addr    (f_wr_addr),
        .job_sample     (f_sample),
        .job_start      (f_start),
        .job_n          (f_n)
    );

    assign q_wdata = {f_flags, f_wr_addr, f_sample, f_start, f_n};

    mwrs_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {b_flags, b_wr_addr, b_sample, b_start, b_n} = q_rdata;

    // The ring is written only by the back part, in word order, so a window
    // under evaluation is never overwritten by a later word.
    mwrs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_wr_addr),
        .wdata (b_sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mwrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // The back sums 2i-(N-1) weighted samples, which equals 2*Sxy-(N-1)*S,
    // scales by six, divides by (N-1)N(N+1) and saturates.
    mwrs_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .job_flags    (b_flags),
        .job_start    (b_start),
        .job_n        (b_n),
        .ram_we       (ram_we),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slope        (slope),
        .slope_valid  (slope_valid)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/mwrs_checker.sv
`default_nettype none

// Watches the ports of the top level.
module mwrs_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [mwrs_pkg::SLOPE_W-1:0]     slope,
    input wire logic                             slope_valid
);

    logic [3:0] pending_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 4'd0;
        end
        else if (in_take && !out_take)
        begin
            pending_reg <= pending_reg + 4'd1;
        end
        else if (out_take && !in_take)
        begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    // A result word that waits keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slope) && $stable(slope_valid))
        else $error("result word changed while stalled");

    // An invalid fit carries a zero slope.
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !slope_valid |-> slope == '0)
        else $error("invalid result with nonzero slope");

    // No result word without an input word behind it.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result word without a pending input word");

    // Queue, back part and output register hold at most four words.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("too many words in flight");

endmodule

bind moving_window_regression_slope mwrs_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .slope       (slope),
    .slope_valid (slope_valid)
);

`default_nettype wire

FILE: verif/tb_moving_window_regression_slope.sv
`default_nettype none

// Self-checking bench for the moving-window regression slope block.
//
// The run has two parts. A short directed part works at the reset window
// length of 14 and then at length 2. It covers the sample extremes, a group
// start on a missing sample, a missing sample in a full window, and a group
// start that carries a sample. A long random part then steps through window
// lengths. These include zero, one, 64 and values above 64, which act as 64.
// Most lengths are small, so the back part's window pass stays short.
// Some phases keep the old window across a length change, so the fit has to
// use the last N stored samples once enough have arrived.
//
// The driver and the monitor are clocked always blocks. The driver takes
// words from a pending queue that the main initial block fills one phase at
// a time. At each accepted input word, the bench's own model of the block
// computes the expected slope and queues it. The monitor checks every
// accepted output word against the oldest queued expectation.
module tb_moving_window_regression_slope;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = 32;
    localparam int RING_DEPTH = 64;
    localparam int IDLE_PCT   = 9;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_WORDS = 700;
    localparam int LEN_W      = mwrs_pkg::LEN_W;
    localparam int SLOPE_W    = mwrs_pkg::SLOPE_W;

    // One input word: a sample and its two flags.
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       missing;
        logic                       restart;
    } sample_word_t;

    // One expected output word.
    typedef struct {
        logic signed [SLOPE_W-1:0] slope;
        logic                      valid;
    } slope_result_t;

    // How the samples of a random phase are chosen.
    typedef enum int {
        FILL_RANDOM,
        FILL_TREND,
        FILL_EXTREME
    } fill_kind_t;

    // Every input has a known value from time zero.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]           cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       sample_missing = 1'b0;
    logic                       group_start = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SLOPE_W-1:0]  slope;
    logic                       slope_valid;

    // Words waiting for the driver, and slopes waiting for the monitor.
    sample_word_t  pending_words[$];
    slope_result_t slopes_due[$];

    // While calm is set, neither side inserts idle cycles.
    bit calm = 1'b0;
    int mismatches = 0;
    int words_queued = 0;

    // The bench's copy of the block state. The ring is never cleared, just
    // like the hardware. The sample count guarantees that only entries
    // written since the last clear are ever read.
    logic signed [SAMPLE_W-1:0] stored_samples [RING_DEPTH];
    logic [5:0]                 ring_wr_ptr = '0;
    int                         stored_count = 0;
    logic [LEN_W-1:0]           length_setting = mwrs_pkg::LEN_RESET;

    moving_window_regression_slope uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .sample_missing (sample_missing),
        .group_start    (group_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slope          (slope),
        .slope_valid    (slope_valid)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Takes one accepted word into the state and returns the slope the block
    // owes for it. The sums stay far inside 64 bits at these widths, so signed
    // longint arithmetic is exact. Its division truncates toward zero, which
    // is the rounding the block uses.
    function automatic slope_result_t predict_slope(input logic signed [SAMPLE_W-1:0] value,
                                                    input logic missing,
                                                    input logic restart);
        slope_result_t r;
        int            n;
        int            idx;
        longint        x;
        longint        s_sum;
        longint        xy_sum;
        longint        num;
        longint        den;
        longint        q;

        r.slope = '0;
        r.valid = 1'b0;
        if (restart)
        begin
            ring_wr_ptr  = '0;
            stored_count = 0;
        end
        if (!missing)
        begin
            stored_samples[ring_wr_ptr] = value;
            ring_wr_ptr = ring_wr_ptr + 6'd1;
            if (stored_count < RING_DEPTH)
                stored_count++;
        end
        n = (length_setting > RING_DEPTH) ? RING_DEPTH : int'(length_setting);
        if (n <= 1 || stored_count < n)
            return r;

        // Position 0 is the oldest sample of the window.
        s_sum  = 0;
        xy_sum = 0;
        for (int i = 0; i < n; i++)
        begin
            idx = (int'(ring_wr_ptr) + RING_DEPTH - n + i) % RING_DEPTH;
            x = stored_samples[idx];
            s_sum  += x;
            xy_sum += longint'(i) * x;
        end
        num = 6 * (2 * xy_sum - longint'(n - 1) * s_sum);
        den = longint'(n - 1) * longint'(n) * longint'(n + 1);
        q = num / den;
        if (q > (64'sd1 <<< (SLOPE_W - 1)) - 1)
            q = (64'sd1 <<< (SLOPE_W - 1)) - 1;
        else if (q < -(64'sd1 <<< (SLOPE_W - 1)))
            q = -(64'sd1 <<< (SLOPE_W - 1));
        r.slope = q[SLOPE_W-1:0];
        r.valid = 1'b1;
        return r;
    endfunction

    // Driver. The input word that was offered before this edge is judged by
    // the pre-edge handshake values. The expectation is queued the moment
    // the word is accepted. A new word goes out only once the previous one
    // is accepted, and in_valid gets one assignment per edge.
    always @(posedge clk)
    begin : driver
        sample_word_t w;

        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                slopes_due.push_back(predict_slope(sample, sample_missing, group_start));
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    w = pending_words.pop_front();
                    in_valid       <= 1'b1;
                    sample         <= w.value;
                    sample_missing <= w.missing;
                    group_start    <= w.restart;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. It checks each accepted output word against the oldest
    // expectation. The receiver stalls at random unless the bench is calm.
    always @(posedge clk)
    begin : monitor
        slope_result_t want;

        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (slopes_due.size() == 0)
                begin
                    $display("%0t: unexpected output word, expected none, got slope %0d valid %0b",
                             $time, slope, slope_valid);
                    mismatches++;
                end
                else
                begin
                    want = slopes_due.pop_front();
                    if (slope !== want.slope)
                    begin
                        $display("%0t: slope mismatch, expected %0d, got %0d",
                                 $time, want.slope, slope);
                        mismatches++;
                    end
                    if (slope_valid !== want.valid)
                    begin
                        $display("%0t: slope_valid mismatch, expected %0b, got %0b",
                                 $time, want.valid, slope_valid);
                        mismatches++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog. The quiet limit leaves a wide margin above the time that a long
    // window pass plus the divider takes.
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;

        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_word(input logic signed [SAMPLE_W-1:0] value,
                             input logic missing, input logic restart);
        sample_word_t w;

        w.value   = value;
        w.missing = missing;
        w.restart = restart;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Returns once the sender has nothing left and every expected slope has
    // come back. Every word gives exactly one result, so the block is idle then.
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || slopes_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Writes the window length. This is only called while the block is idle.
    task automatic set_length(input logic [LEN_W-1:0] len);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        length_setting = len;
        @(negedge clk);
    endtask

    // Queues one random phase. Mostly these are runs long enough to fill the
    // window, with a few missing samples and rare group starts mixed in.
    task automatic push_phase(input int count, input fill_kind_t kind,
                              input bit restart_first);
        logic signed [SAMPLE_W-1:0] value;
        longint                     level;
        longint                     step;

        level = longint'($signed($urandom));
        step  = longint'($urandom_range(4000)) - 2000;
        step  = step * longint'($urandom_range(1, 512));
        for (int i = 0; i < count; i++)
        begin
            case (kind)
                FILL_TREND:
                begin
                    // A linear trend with noise, wrapping at 32 bits.
                    value = level[SAMPLE_W-1:0];
                    level = level + step + longint'($urandom_range(1023)) - 512;
                end
                FILL_EXTREME:
                begin
                    case ($urandom_range(3))
                        0:       value = 32'sh7fff_ffff;
                        1:       value = 32'sh8000_0000;
                        2:       value = '0;
                        default: value = $urandom;
                    endcase
                end
                default:
                begin
                    value = $urandom;
                end
            endcase
            push_word(value, $urandom_range(99) < 8,
                      (i == 0 && restart_first) || $urandom_range(99) == 0);
        end
    endtask

    initial
    begin : main
        int         phase;
        int         len;
        int         count;
        fill_kind_t kind;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset length of 14. It opens with a group
        // start on a missing sample, which clears the state and gives an
        // invalid result. Seven minimum samples then seven maximum samples
        // give a steep positive fit from samples at full magnitude.
        push_word(32'sh7fff_ffff, 1'b1, 1'b1);
        for (int i = 0; i < 14; i++)
            push_word((i < 7) ? 32'sh8000_0000 : 32'sh7fff_ffff, 1'b0, 1'b0);
        // A missing sample leaves the window as it is, so the slope repeats.
        push_word(32'sh0000_0000, 1'b1, 1'b0);
        push_word(-32'sd1, 1'b0, 1'b0);
        // A group start that carries a sample: the state is cleared first,
        // so the window is not full and the result is invalid.
        push_word(32'sh0001_0000, 1'b0, 1'b1);

        // At length 2 the fit is simply the difference of the last two
        // samples. Going between the two extremes gives the largest slopes
        // of both signs.
        set_length(7'd2);
        push_word(32'sh8000_0000, 1'b0, 1'b1);
        push_word(32'sh7fff_ffff, 1'b0, 1'b0);
        push_word(32'sh8000_0000, 1'b0, 1'b0);
        push_word(32'sh0000_0000, 1'b0, 1'b0);

        // Random part. The first lengths are fixed: zero and one are always
        // invalid, 127 and 65 act as 64, and 64 is the largest real window.
        // After those come small random lengths with an occasional 64.
        phase = 0;
        while (words_queued < RANDOM_WORDS + 22)
        begin
            case (phase)
                0:       len = 0;
                1:       len = 1;
                2:       len = 127;
                3:       len = 5;
                4:       len = 65;
                5:       len = 3;
                6:       len = 64;
                7:       len = 9;
                default: len = ($urandom_range(9) == 0) ? 64 : $urandom_range(2, 24);
            endcase
            if (len >= RING_DEPTH)
                count = 90;
            else
                count = $urandom_range(20, 60);
            kind = fill_kind_t'($urandom_range(2));

            // Waiting for every result before each write also makes the
            // sender pause at each phase boundary.
            set_length(len[LEN_W-1:0]);
            // A long stretch with no idle cycles on either side.
            calm = (phase >= 8 && phase <= 10);
            // Some phases keep the old window, so a new length applies to
            // samples that were stored before the write.
            push_phase(count, kind, $urandom_range(3) != 0);
            phase++;
        end

        wait_drained();
        repeat (200) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/mwrs_pkg.sv
hw/rtl/mwrs_ram.sv
hw/rtl/mwrs_queue.sv
hw/rtl/mwrs_front.sv
hw/rtl/mwrs_div.sv
hw/rtl/mwrs_back.sv
hw/rtl/moving_window_regression_slope.sv
hw/rtl/mwrs_checker.sv
verif/tb_moving_window_regression_slope.sv
